@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the edge classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock edge outside reset.
`define BSEC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define BSEC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/bsec_pkg.sv @@
// ----------------------------------------------------------------------------
// bsec_pkg
// Types and constants shared by the edge classifier front, queue and back.
// ----------------------------------------------------------------------------
package bsec_pkg;

    localparam int FLAG_W      = 4;
    localparam int DIM_CFG_W   = 14;
    localparam int MARGIN_W    = 12;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 27;
    localparam int NUM_COUNTS  = 6;
    localparam int VERDICT_W   = 3;
    localparam int SHIFT_W     = 2;
    // Must be a power of two: the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAG_BIT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARGIN_COLS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARGIN_ROWS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_LEFT   = 3'd5;

    // Pixel classes against the left and right neighbors.
    localparam logic [1:0] CLS_MAX = 2'd0;
    localparam logic [1:0] CLS_MIN = 2'd1;
    localparam logic [1:0] CLS_MID = 2'd2;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERD_IDENT     = 3'd0;
    localparam logic [VERDICT_W-1:0] VERD_LEFT      = 3'd1;
    localparam logic [VERDICT_W-1:0] VERD_RIGHT     = 3'd2;
    localparam logic [VERDICT_W-1:0] VERD_AMB_LEFT  = 3'd3;
    localparam logic [VERDICT_W-1:0] VERD_AMB_RIGHT = 3'd4;
    localparam logic [VERDICT_W-1:0] VERD_UNCORR    = 3'd5;

    localparam logic signed [SHIFT_W-1:0] SHIFT_NONE  = 2'sd0;
    localparam logic signed [SHIFT_W-1:0] SHIFT_LEFT  = -2'sd1;
    localparam logic signed [SHIFT_W-1:0] SHIFT_RIGHT = 2'sd1;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [FLAG_W-1:0]    flag_bit;
        logic [DIM_CFG_W-1:0] frame_width;
        logic [DIM_CFG_W-1:0] frame_height;
        logic [MARGIN_W-1:0]  margin_cols;
        logic [MARGIN_W-1:0]  margin_rows;
        logic                 force_left;
    } t_cfg;

    // One command from the front to the back.
    typedef struct packed {
        logic       rise;
        logic       fall;
        logic [1:0] cls;
        logic       last;
    } t_cmd;

endpackage

@@ rtl/core/bsec_front.sv @@
// ----------------------------------------------------------------------------
// bsec_front
// Tracks raster position, keeps a three-pixel window and classifies edges.
// ----------------------------------------------------------------------------
module bsec_front #(
    parameter int MAX_DIM    = 8192,
    parameter int PIXEL_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsec_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  logic [15:0]     i_pixel,
    input  logic            i_queue_ready,
    output logic            o_ready,
    output logic            o_push,
    output bsec_pkg::t_cmd  o_cmd
);
    import bsec_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CW    = ((DIM_W > MARGIN_W) ? DIM_W : MARGIN_W) + 1;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    logic [IDX_W-1:0]      r_col, n_col;
    logic [IDX_W-1:0]      r_row, n_row;
    logic [PIXEL_BITS-1:0] r_win0, r_win1;

    logic [CW-1:0]         w_w, w_h, w_mc, w_mr;
    logic [CW-1:0]         w_c, w_r, w_r1, w_cm1;
    logic                  w_wrap_c, w_judge, w_row_end, w_last, w_accept;
    logic [PIXEL_BITS-1:0] w_p, w_sl, w_sm, w_sr;
    logic                  w_fl, w_fm, w_fr;
    logic [1:0]            w_cls;

    assign w_w  = CW'(eff_dim(i_cfg.frame_width));
    assign w_h  = CW'(eff_dim(i_cfg.frame_height));
    assign w_mc = (i_cfg.margin_cols == '0) ? CW'(1) : CW'(i_cfg.margin_cols);
    assign w_mr = CW'(i_cfg.margin_rows);

    // A frame size written smaller than the current position wraps it here.
    assign w_wrap_c = CW'(r_col) >= w_w;
    assign w_c      = w_wrap_c ? '0 : CW'(r_col);
    assign w_r1     = CW'(r_row) + (w_wrap_c ? CW'(1) : CW'(0));
    assign w_r      = (w_r1 >= w_h) ? '0 : w_r1;
    assign w_cm1    = w_c - CW'(1);

    // The middle pixel of the window sits at column c-1 and is judged now.
    assign w_judge = (w_c >= CW'(2)) && (w_cm1 >= w_mc) && ((w_cm1 + w_mc) < w_w)
                  && (w_r >= w_mr) && ((w_r + w_mr) < w_h)
                  && (32'(i_cfg.flag_bit) < PIXEL_BITS);

    assign w_p  = i_pixel[PIXEL_BITS-1:0];
    assign w_sl = r_win0 >> i_cfg.flag_bit;
    assign w_sm = r_win1 >> i_cfg.flag_bit;
    assign w_sr = w_p >> i_cfg.flag_bit;
    assign w_fl = w_sl[0];
    assign w_fm = w_sm[0];
    assign w_fr = w_sr[0];

    always_comb begin
        if (r_win1 > r_win0 && r_win1 > w_p) begin
            w_cls = CLS_MAX;
        end else if (r_win1 < r_win0 && r_win1 < w_p) begin
            w_cls = CLS_MIN;
        end else begin
            w_cls = CLS_MID;
        end
    end

    assign w_row_end = (w_c + CW'(1)) >= w_w;
    assign w_last    = w_row_end && ((w_r + CW'(1)) >= w_h);

    assign o_cmd.rise = w_judge && w_fm && !w_fl;
    assign o_cmd.fall = w_judge && w_fm && !w_fr;
    assign o_cmd.cls  = w_cls;
    assign o_cmd.last = w_last;

    assign o_ready  = i_queue_ready;
    assign w_accept = i_valid && i_queue_ready;
    // Beats that change no counter and end no frame need no queue slot.
    assign o_push   = w_accept && (o_cmd.rise || o_cmd.fall || w_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_last) begin
                n_col = '0;
                n_row = '0;
            end else if (w_row_end) begin
                n_col = '0;
                n_row = IDX_W'(w_r + CW'(1));
            end else begin
                n_col = IDX_W'(w_c + CW'(1));
                n_row = IDX_W'(w_r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_win0 <= '0;
            r_win1 <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_accept) begin
                r_win0 <= r_win1;
                r_win1 <= w_p;
            end
        end
    end

endmodule

@@ rtl/core/bsec_queue.sv @@
// ----------------------------------------------------------------------------
// bsec_queue
// Small command queue that decouples the classifier front from the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsec_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsec_pkg::t_cmd  i_cmd,
    output logic            o_not_full,
    output logic            o_valid,
    output bsec_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import bsec_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_pop;

    assign o_not_full = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid    = r_count != '0;
    assign o_cmd      = r_mem[r_rptr];
    assign w_do_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    `BSEC_NEVER(a_push_full, i_clk, i_rst_n, i_push && !o_not_full, "queue push while full")
    `BSEC_ASSERT(a_ptr_track, i_clk, i_rst_n, (r_count == '0) |-> (r_wptr == r_rptr), "queue pointers disagree with empty count")

endmodule

@@ rtl/core/bsec_back.sv @@
// ----------------------------------------------------------------------------
// bsec_back
// Applies class counter updates and computes the frame verdict over cycles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsec_back (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_force_left,
    input  logic                                     i_q_valid,
    input  bsec_pkg::t_cmd                           i_q_cmd,
    output logic                                     o_q_pop,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [bsec_pkg::VERDICT_W-1:0]           o_verdict,
    output logic signed [bsec_pkg::SHIFT_W-1:0]      o_shift,
    output bsec_pkg::t_count                         o_counts [bsec_pkg::NUM_COUNTS]
);
    import bsec_pkg::*;

    localparam int TOT_W  = COUNT_W + 2;
    localparam int WIDE_W = TOT_W + 8;
    localparam int PROD_W = COUNT_W + TOT_W;

    localparam logic [2:0] V_IDLE = 3'd0;
    localparam logic [2:0] V_TOT  = 3'd1;
    localparam logic [2:0] V_TEST = 3'd2;
    localparam logic [2:0] V_FIN  = 3'd3;
    localparam logic [2:0] V_OUT  = 3'd4;

    logic [2:0]          r_state, n_state;
    t_count              r_cnt  [NUM_COUNTS];
    t_count              n_cnt  [NUM_COUNTS];
    t_count              r_snap [NUM_COUNTS];
    logic [TOT_W-1:0]    r_tm, r_td;
    logic [PROD_W-1:0]   r_p_mm_td, r_p_dm_tm;
    logic                r_ok;
    logic                r_mi_lt10, r_mm_gt50, r_mm_mn10, r_mi_gt50, r_mi_mm10, r_mi_mn20;
    logic                r_di_lt10, r_dm_gt50, r_dm_dn10, r_di_gt50, r_di_dm10, r_di_dn20;
    logic                r_mi_gt65, r_di_gt65;
    logic [VERDICT_W-1:0]       r_verdict, n_verdict;
    logic signed [SHIFT_W-1:0]  r_shift, n_shift;

    logic                w_pop_last;
    logic [WIDE_W-1:0]   w_mm, w_mn, w_mi, w_dm, w_dn, w_di, w_tm, w_td;
    logic                w_left, w_right, w_ident;

    // A frame end waits until the verdict unit is free; plain updates never wait.
    assign o_q_pop    = i_q_valid && (!i_q_cmd.last || r_state == V_IDLE);
    assign w_pop_last = o_q_pop && i_q_cmd.last;

    always_comb begin
        for (int k = 0; k < NUM_COUNTS; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        if (o_q_pop) begin
            for (int k = 0; k < 3; k++) begin
                if (i_q_cmd.rise && i_q_cmd.cls == 2'(k) && r_cnt[k] != '1) begin
                    n_cnt[k] = r_cnt[k] + COUNT_W'(1);
                end
                if (i_q_cmd.fall && i_q_cmd.cls == 2'(k) && r_cnt[k+3] != '1) begin
                    n_cnt[k+3] = r_cnt[k+3] + COUNT_W'(1);
                end
            end
        end
    end

    assign w_mm = WIDE_W'(r_snap[0]);
    assign w_mn = WIDE_W'(r_snap[1]);
    assign w_mi = WIDE_W'(r_snap[2]);
    assign w_dm = WIDE_W'(r_snap[3]);
    assign w_dn = WIDE_W'(r_snap[4]);
    assign w_di = WIDE_W'(r_snap[5]);
    assign w_tm = WIDE_W'(r_tm);
    assign w_td = WIDE_W'(r_td);

    assign w_left  = r_ok && r_mi_lt10 && r_mm_gt50 && r_mm_mn10
                  && r_di_gt50 && r_di_dm10 && r_di_dn20;
    assign w_right = r_ok && r_di_lt10 && r_dm_gt50 && r_dm_dn10
                  && r_mi_gt50 && r_mi_mm10 && r_mi_mn20;
    assign w_ident = r_ok && r_mi_gt65 && r_di_gt65;

    always_comb begin
        if (i_force_left || (!w_ident && w_left)) begin
            n_verdict = VERD_LEFT;
            n_shift   = SHIFT_LEFT;
        end else if (w_ident) begin
            n_verdict = VERD_IDENT;
            n_shift   = SHIFT_NONE;
        end else if (w_right) begin
            n_verdict = VERD_RIGHT;
            n_shift   = SHIFT_RIGHT;
        end else if (r_mi_lt10) begin
            // Both shares carry the same factor of 100, so it cancels here.
            if (r_ok && r_p_mm_td > r_p_dm_tm) begin
                n_verdict = VERD_AMB_LEFT;
                n_shift   = SHIFT_LEFT;
            end else begin
                n_verdict = VERD_AMB_RIGHT;
                n_shift   = SHIFT_RIGHT;
            end
        end else begin
            n_verdict = VERD_UNCORR;
            n_shift   = SHIFT_NONE;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            V_IDLE: begin
                if (w_pop_last) begin
                    n_state = V_TOT;
                end
            end
            V_TOT:  n_state = V_TEST;
            V_TEST: n_state = V_FIN;
            V_FIN:  n_state = V_OUT;
            V_OUT: begin
                if (i_ready) begin
                    n_state = V_IDLE;
                end
            end
            default: n_state = V_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_IDLE;
            for (int k = 0; k < NUM_COUNTS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            for (int k = 0; k < NUM_COUNTS; k++) begin
                r_cnt[k] <= w_pop_last ? '0 : n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_last) begin
            for (int k = 0; k < NUM_COUNTS; k++) begin
                r_snap[k] <= n_cnt[k];
            end
        end
        if (r_state == V_TOT) begin
            r_tm <= TOT_W'(r_snap[0]) + TOT_W'(r_snap[1]) + TOT_W'(r_snap[2]);
            r_td <= TOT_W'(r_snap[3]) + TOT_W'(r_snap[4]) + TOT_W'(r_snap[5]);
        end
        if (r_state == V_TEST) begin
            r_ok      <= (r_tm != '0) && (r_td != '0);
            r_p_mm_td <= PROD_W'(r_snap[0]) * PROD_W'(r_td);
            r_p_dm_tm <= PROD_W'(r_snap[3]) * PROD_W'(r_tm);
            r_mi_lt10 <= w_mi * 100 < w_tm * 10;
            r_mm_gt50 <= w_mm * 100 > w_tm * 50;
            r_mm_mn10 <= w_mm * 100 > w_mn * 100 + w_tm * 10;
            r_mi_gt50 <= w_mi * 100 > w_tm * 50;
            r_mi_mm10 <= w_mi * 100 > w_mm * 100 + w_tm * 10;
            r_mi_mn20 <= w_mi * 100 > w_mn * 100 + w_tm * 20;
            r_di_lt10 <= w_di * 100 < w_td * 10;
            r_dm_gt50 <= w_dm * 100 > w_td * 50;
            r_dm_dn10 <= w_dm * 100 > w_dn * 100 + w_td * 10;
            r_di_gt50 <= w_di * 100 > w_td * 50;
            r_di_dm10 <= w_di * 100 > w_dm * 100 + w_td * 10;
            r_di_dn20 <= w_di * 100 > w_dn * 100 + w_td * 20;
            r_mi_gt65 <= w_mi * 100 > w_tm * 65;
            r_di_gt65 <= w_di * 100 > w_td * 65;
        end
        if (r_state == V_FIN) begin
            r_verdict <= n_verdict;
            r_shift   <= n_shift;
        end
    end

    assign o_valid   = r_state == V_OUT;
    assign o_verdict = r_verdict;
    assign o_shift   = r_shift;
    assign o_counts  = r_snap;

    `BSEC_NEVER(a_last_busy, i_clk, i_rst_n, w_pop_last && r_state != V_IDLE, "frame end taken while verdict busy")
    `BSEC_ASSERT(a_clear, i_clk, i_rst_n, w_pop_last |=> (r_cnt[0] == '0 && r_cnt[5] == '0), "counters not cleared at frame end")
    `BSEC_ASSERT(a_shift_none, i_clk, i_rst_n, (o_valid && (o_verdict == VERD_IDENT || o_verdict == VERD_UNCORR)) |-> (o_shift == SHIFT_NONE), "nonzero shift for uncorrected verdict")
    `BSEC_ASSERT(a_code, i_clk, i_rst_n, o_valid |-> (o_verdict <= VERD_UNCORR), "verdict code out of range")

endmodule

@@ rtl/core/byte_shift_edge_classifier.sv @@
// ----------------------------------------------------------------------------
// byte_shift_edge_classifier
// Frame edge-shift classifier: counts flag edges by local extremum class.
// ----------------------------------------------------------------------------
// Usage: pixels of one frame enter on i_pixel in raster order with an
// i_valid/o_ready handshake, one beat per pixel; the block sustains one pixel
// per cycle while o_ready is high. Only the last pixel of a frame produces an
// output beat (o_valid/i_ready) carrying the verdict, the shift and the six
// class counts; its command passes the queue and states V_TOT, V_TEST and
// V_FIN before V_OUT shows it. A frame end waits while the verdict unit is
// busy, so short frames can stall input. A four-entry command queue sits
// between the pixel front and the counter back. If the receiver stalls the
// output, counting continues until the next frame end reaches the head of the
// queue; the queue then fills and o_ready drops. Configuration must be written
// through i_cfg_we/i_cfg_index/i_cfg_data while the block is idle; the block
// does not enforce this. Reset restores the default registers, clears the
// position, the pixel window and the counters, and empties the queue.
// ----------------------------------------------------------------------------
module byte_shift_edge_classifier #(
    parameter int MAX_DIM    = 8192,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bsec_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [bsec_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [15:0]                           i_pixel,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [2:0]                            o_verdict,
    output logic signed [1:0]                     o_shift,
    output logic [26:0]                           o_rise_max_count,
    output logic [26:0]                           o_rise_min_count,
    output logic [26:0]                           o_rise_mid_count,
    output logic [26:0]                           o_fall_max_count,
    output logic [26:0]                           o_fall_min_count,
    output logic [26:0]                           o_fall_mid_count
);
    import bsec_pkg::*;

    t_cfg   r_cfg;
    t_cmd   w_front_cmd, w_q_cmd;
    logic   w_push, w_not_full, w_q_valid, w_pop;
    t_count w_counts [NUM_COUNTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_bit     <= FLAG_W'(8);
            r_cfg.frame_width  <= DIM_CFG_W'(1024);
            r_cfg.frame_height <= DIM_CFG_W'(1024);
            r_cfg.margin_cols  <= MARGIN_W'(100);
            r_cfg.margin_rows  <= MARGIN_W'(100);
            r_cfg.force_left   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FLAG_BIT:     r_cfg.flag_bit     <= i_cfg_data[FLAG_W-1:0];
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_MARGIN_COLS:  r_cfg.margin_cols  <= i_cfg_data[MARGIN_W-1:0];
                CFG_MARGIN_ROWS:  r_cfg.margin_rows  <= i_cfg_data[MARGIN_W-1:0];
                CFG_FORCE_LEFT:   r_cfg.force_left   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bsec_front #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .i_pixel       (i_pixel),
        .i_queue_ready (w_not_full),
        .o_ready       (o_ready),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    bsec_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_front_cmd),
        .o_not_full (w_not_full),
        .o_valid    (w_q_valid),
        .o_cmd      (w_q_cmd),
        .i_pop      (w_pop)
    );

    bsec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_force_left (r_cfg.force_left),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_verdict    (o_verdict),
        .o_shift      (o_shift),
        .o_counts     (w_counts)
    );

    assign o_rise_max_count = w_counts[0];
    assign o_rise_min_count = w_counts[1];
    assign o_rise_mid_count = w_counts[2];
    assign o_fall_max_count = w_counts[3];
    assign o_fall_min_count = w_counts[4];
    assign o_fall_mid_count = w_counts[5];

endmodule
